FILE: sv/frdr_pkg.sv
package frdr_pkg;

    localparam int WORD_W  = 64;
    localparam int WPR_W   = 8;
    localparam int RPF_W   = 11;
    localparam int TOP_W   = 10;
    localparam int ROWS_W  = 11;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [WPR_W-1:0] WPR_RESET = WPR_W'(60);
    localparam logic [RPF_W-1:0] RPF_RESET = RPF_W'(600);

    typedef logic [0:0] reg_index_t;

    localparam reg_index_t REG_WORDS_PER_ROW  = 1'b0;
    localparam reg_index_t REG_ROWS_PER_FRAME = 1'b1;

endpackage

FILE: sv/frame_dirty_row_detector_top.sv
// A transaction is registered in s1_valid_reg and s1_diff_reg, and its region, if any, in the result register.
// Throughput: one word pair per cycle; input stalls only while the result
// register is full and held by out_stall.
// Reset: asynchronous, active low; clears position counters, run state and both
// valid flags, and loads words_per_row = 60, rows_per_frame = 600.
module frame_dirty_row_detector_top
    import frdr_pkg::*;
#(
    parameter int MAX_WORDS_PER_ROW = 128,
    parameter int MAX_ROWS          = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [WORD_W-1:0]   old_word,
    input  logic [WORD_W-1:0]   new_word,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [TOP_W-1:0]    region_top,
    output logic [ROWS_W-1:0]   region_rows,
    output logic                frame_last,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int WC_W  = (MAX_WORDS_PER_ROW > 1) ? $clog2(MAX_WORDS_PER_ROW) : 1;
    localparam int WSA_W = $clog2(MAX_WORDS_PER_ROW + 1);
    localparam int WS_W  = (WSA_W > WPR_W) ? WSA_W : WPR_W;
    localparam int RC_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RSA_W = $clog2(MAX_ROWS + 1);
    localparam int RS_W  = (RSA_W > RPF_W) ? RSA_W : RPF_W;

    logic [WPR_W-1:0]  words_per_row_reg;
    logic [RPF_W-1:0]  rows_per_frame_reg;

    logic              s1_valid_reg;
    logic              s1_diff_reg;

    logic [WC_W-1:0]   word_count_reg;
    logic [WC_W-1:0]   word_count_next;
    logic [RC_W-1:0]   row_count_reg;
    logic [RC_W-1:0]   row_count_next;
    logic              row_has_diff_reg;
    logic              row_has_diff_next;
    logic              run_active_reg;
    logic              run_active_next;
    logic [RC_W-1:0]   run_first_row_reg;
    logic [RC_W-1:0]   run_first_row_next;

    logic              out_valid_reg;
    logic [TOP_W-1:0]  region_top_reg;
    logic [ROWS_W-1:0] region_rows_reg;
    logic              frame_last_reg;

    logic              advance;
    logic              step;
    logic              cfg_write;
    reg_index_t        cfg_index;

    logic [WS_W-1:0]   wpr_ext;
    logic [WS_W-1:0]   wpr_eff;
    logic [RS_W-1:0]   rpf_ext;
    logic [RS_W-1:0]   rpf_eff;
    logic              word_end;
    logic              last_row;
    logic              dirty;
    logic              emit;
    logic [RC_W-1:0]   first_row;
    logic [RS_W-1:0]   end_row;
    logic [RS_W-1:0]   span;

    // APB
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[2:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_per_row_reg  <= WPR_RESET;
            rows_per_frame_reg <= RPF_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WORDS_PER_ROW:  words_per_row_reg  <= pwdata[WPR_W-1:0];
                REG_ROWS_PER_FRAME: rows_per_frame_reg <= pwdata[RPF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_WORDS_PER_ROW:  prdata = PDATA_W'(words_per_row_reg);
            REG_ROWS_PER_FRAME: prdata = PDATA_W'(rows_per_frame_reg);
            default:            prdata = '0;
        endcase
    end

    // handshake
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign step     = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_diff_reg <= (old_word != new_word);
        end
    end

    // clamp frame size
    always_comb
    begin
        wpr_ext = WS_W'(words_per_row_reg);
        rpf_ext = RS_W'(rows_per_frame_reg);

        if (words_per_row_reg == '0)
            wpr_eff = WS_W'(1);
        else if (wpr_ext > WS_W'(MAX_WORDS_PER_ROW))
            wpr_eff = WS_W'(MAX_WORDS_PER_ROW);
        else
            wpr_eff = wpr_ext;

        if (rows_per_frame_reg == '0)
            rpf_eff = RS_W'(1);
        else if (rpf_ext > RS_W'(MAX_ROWS))
            rpf_eff = RS_W'(MAX_ROWS);
        else
            rpf_eff = rpf_ext;
    end

    // row and run tracking
    always_comb
    begin
        dirty     = row_has_diff_reg || s1_diff_reg;
        word_end  = (WS_W'(word_count_reg) + WS_W'(1)) >= wpr_eff;
        last_row  = (RS_W'(row_count_reg) + RS_W'(1)) >= rpf_eff;
        first_row = run_active_reg ? run_first_row_reg : row_count_reg;
        end_row   = (dirty && last_row) ? (RS_W'(row_count_reg) + RS_W'(1))
                                        : RS_W'(row_count_reg);
        span      = end_row - RS_W'(first_row);

        word_count_next    = word_count_reg;
        row_count_next     = row_count_reg;
        row_has_diff_next  = row_has_diff_reg;
        run_active_next    = run_active_reg;
        run_first_row_next = run_first_row_reg;
        emit               = 1'b0;

        if (step)
        begin
            if (!word_end)
            begin
                word_count_next   = word_count_reg + WC_W'(1);
                row_has_diff_next = dirty;
            end
            else
            begin
                if (dirty)
                begin
                    run_active_next    = 1'b1;
                    run_first_row_next = first_row;
                    emit               = last_row;
                end
                else
                begin
                    emit = run_active_reg;
                end

                if (emit)
                    run_active_next = 1'b0;

                word_count_next   = '0;
                row_has_diff_next = 1'b0;
                row_count_next    = last_row ? '0 : row_count_reg + RC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg    <= '0;
            row_count_reg     <= '0;
            row_has_diff_reg  <= 1'b0;
            run_active_reg    <= 1'b0;
            run_first_row_reg <= '0;
        end
        else
        begin
            word_count_reg    <= word_count_next;
            row_count_reg     <= row_count_next;
            row_has_diff_reg  <= row_has_diff_next;
            run_active_reg    <= run_active_next;
            run_first_row_reg <= run_first_row_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            region_top_reg  <= TOP_W'(first_row);
            region_rows_reg <= ROWS_W'(span);
            frame_last_reg  <= last_row;
        end
    end

    assign out_valid   = out_valid_reg;
    assign region_top  = region_top_reg;
    assign region_rows = region_rows_reg;
    assign frame_last  = frame_last_reg;

endmodule

FILE: sv/frdr_checker.sv
module frdr_checker
    import frdr_pkg::*;
#(
    parameter int MAX_ROWS = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_stall,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [TOP_W-1:0]    region_top,
    input  logic [ROWS_W-1:0]   region_rows,
    input  logic                frame_last,
    input  logic                pready
);

    localparam int SUM_W = ROWS_W + 1;

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(region_top)
            && $stable(region_rows) && $stable(frame_last))
    else $error("stalled result changed");

    // a region always covers at least one row
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> region_rows != '0)
    else $error("empty region");

    // a region never extends past the largest frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (MAX_ROWS <= 1024) |->
            (SUM_W'(region_top) + SUM_W'(region_rows)) <= SUM_W'(MAX_ROWS))
    else $error("region beyond frame");

    // input only stalls behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

    assert property (@(posedge clk) disable iff (!rst_n)
        pready)
    else $error("pready low");

endmodule

bind frame_dirty_row_detector_top frdr_checker #(
    .MAX_ROWS (MAX_ROWS)
) u_frdr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .region_top  (region_top),
    .region_rows (region_rows),
    .frame_last  (frame_last),
    .pready      (pready)
);

FILE: tb/sv/frame_dirty_row_detector_top_tb.sv
`timescale 1ns / 1ps

module frame_dirty_row_detector_top_tb
    import frdr_pkg::*;
();

    localparam int CLK_PERIOD   = 12;
    localparam int MAX_WORDS    = 128;
    localparam int MAX_HEIGHT   = 1024;
    localparam int RESULT_DELAY = 2;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct packed {
        logic [TOP_W-1:0]  first_row;
        logic [ROWS_W-1:0] row_total;
        logic              at_frame_end;
    } region_t;

    typedef enum int { STALL_NONE, STALL_RANDOM, STALL_HOLD } stall_mode_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [WORD_W-1:0]   old_word;
    logic [WORD_W-1:0]   new_word;
    logic                out_valid;
    logic                out_stall;
    logic [TOP_W-1:0]    region_top;
    logic [ROWS_W-1:0]   region_rows;
    logic                frame_last;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    logic [WPR_W-1:0] cfg_words_per_row  = WPR_RESET;
    logic [RPF_W-1:0] cfg_rows_per_frame = RPF_RESET;
    int  word_pos  = 0;
    int  row_pos   = 0;
    bit  row_dirty = 1'b0;
    bit  run_open  = 1'b0;
    int  run_top   = 0;

    region_t pending_regions[$];

    int  error_count   = 0;
    int  pairs_sent    = 0;
    int  regions_seen  = 0;
    int  size_writes   = 0;
    int  cycle_count   = 0;
    bit  gaps_on       = 1'b0;
    int  burst_left    = 0;

    stall_mode_t stall_mode = STALL_NONE;
    int          stall_span = 0;
    int          hold_left  = 0;

    frame_dirty_row_detector_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .old_word    (old_word),
        .new_word    (new_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .region_top  (region_top),
        .region_rows (region_rows),
        .frame_last  (frame_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("frame_dirty_row_detector_top_tb: timeout after %0d cycles", cycle_count);
            $display("frame_dirty_row_detector_top_tb: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 2));
            stall_span = $urandom_range(20, 150);
        end
        else
        begin
            stall_span--;
        end
        case (stall_mode)
            STALL_NONE:
                out_stall <= 1'b0;
            STALL_RANDOM:
                out_stall <= ($urandom_range(0, 2) == 0);
            default:
            begin
                if (hold_left > 0)
                begin
                    hold_left--;
                    out_stall <= 1'b1;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    hold_left = $urandom_range(3, 20);
                    out_stall <= 1'b1;
                end
                else
                begin
                    out_stall <= 1'b0;
                end
            end
        endcase
    end

    always @(posedge clk)
    begin : check_region
        region_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            regions_seen++;
            if (pending_regions.size() == 0)
            begin
                $error("region with none expected: region_top %0d region_rows %0d frame_last %0d",
                       region_top, region_rows, frame_last);
                error_count++;
            end
            else
            begin
                want = pending_regions.pop_front();
                if (region_top !== want.first_row)
                begin
                    $error("region_top expected %0d actual %0d", want.first_row, region_top);
                    error_count++;
                end
                if (region_rows !== want.row_total)
                begin
                    $error("region_rows expected %0d actual %0d", want.row_total, region_rows);
                    error_count++;
                end
                if (frame_last !== want.at_frame_end)
                begin
                    $error("frame_last expected %0d actual %0d", want.at_frame_end, frame_last);
                    error_count++;
                end
            end
        end
    end

    function automatic int clamp_dim(input int v, input int limit);
        if (v == 0)
            return 1;
        return (v > limit) ? limit : v;
    endfunction

    function automatic void scan_pair(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
        int      width;
        int      height;
        bit      dirty;
        bit      last_row;
        bit      emit;
        int      end_row;
        region_t r;
        width  = clamp_dim(cfg_words_per_row, MAX_WORDS);
        height = clamp_dim(cfg_rows_per_frame, MAX_HEIGHT);
        dirty  = row_dirty || (a != b);
        if (word_pos + 1 < width)
        begin
            word_pos++;
            row_dirty = dirty;
            return;
        end
        last_row = (row_pos + 1 >= height);
        end_row  = row_pos;
        emit     = 1'b0;
        if (dirty)
        begin
            if (!run_open)
            begin
                run_open = 1'b1;
                run_top  = row_pos;
            end
            if (last_row)
            begin
                end_row = row_pos + 1;
                emit    = 1'b1;
            end
        end
        else if (run_open)
        begin
            emit = 1'b1;
        end
        if (emit)
        begin
            r.first_row    = TOP_W'(run_top);
            r.row_total    = ROWS_W'(end_row - run_top);
            r.at_frame_end = last_row;
            pending_regions.insert(pending_regions.size(), r);
            run_open = 1'b0;
        end
        word_pos  = 0;
        row_dirty = 1'b0;
        row_pos   = last_row ? 0 : row_pos + 1;
    endfunction

    task automatic send_pair(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
        if (gaps_on && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        in_valid <= 1'b1;
        old_word <= a;
        new_word <= b;
        do
            @(posedge clk);
        while (in_stall);
        scan_pair(a, b);
        pairs_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic send_row(input int words, input bit dirty);
        int               hot;
        logic [WORD_W-1:0] a;
        hot = $urandom_range(0, words - 1);
        for (int w = 0; w < words; w++)
        begin
            a = {$urandom, $urandom};
            send_pair(a, (dirty && w == hot) ? a ^ (64'd1 << $urandom_range(0, 63)) : a);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_regions.size() != 0)
            @(posedge clk);
        repeat (RESULT_DELAY + 2) @(posedge clk);
    endtask

    task automatic write_size(input reg_index_t idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] want;
        drain();
        if (idx == REG_WORDS_PER_ROW)
            cfg_words_per_row = value[WPR_W-1:0];
        else
            cfg_rows_per_frame = value[RPF_W-1:0];
        want = (idx == REG_WORDS_PER_ROW) ? PDATA_W'(cfg_words_per_row)
                                          : PDATA_W'(cfg_rows_per_frame);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
        begin
            $error("prdata expected %0d actual %0d", want, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        size_writes++;
        @(posedge clk);
    endtask

    task automatic test_reset_size();
        logic [WORD_W-1:0] a;
        for (int w = 0; w < 60; w++)
        begin
            a = {$urandom, $urandom};
            send_pair(a, (w == 59) ? ~a : a);
        end
        send_row(60, 1'b0);
        drain();
    endtask

    task automatic test_shrink_midframe();
        write_size(REG_WORDS_PER_ROW, 8);
        write_size(REG_ROWS_PER_FRAME, 8);
        send_row(8, 1'b1);
        send_row(8, 1'b1);
        for (int w = 0; w < 5; w++)
            send_pair(64'h0123_4567_89ab_cdef, 64'h0123_4567_89ab_cdef);
        write_size(REG_WORDS_PER_ROW, 2);
        write_size(REG_ROWS_PER_FRAME, 2);
        send_pair(64'h0, 64'h0);
        send_row(2, 1'b0);
        drain();
    endtask

    task automatic test_zero_size_extremes();
        logic [WORD_W-1:0] a;
        a = {$urandom, $urandom};
        write_size(REG_WORDS_PER_ROW, 0);
        write_size(REG_ROWS_PER_FRAME, 0);
        send_pair('0, '0);
        send_pair('0, '1);
        send_pair('1, '1);
        send_pair('1, '0);
        send_pair(a, a ^ 64'h8000_0000_0000_0000);
        send_pair(a, a ^ 64'h1);
        send_pair(a, a);
        send_pair(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        drain();
    endtask

    task automatic test_last_row_clean();
        write_size(REG_WORDS_PER_ROW, 2);
        write_size(REG_ROWS_PER_FRAME, 3);
        send_row(2, 1'b0);
        send_row(2, 1'b1);
        send_row(2, 1'b0);
        send_row(2, 1'b1);
        send_row(2, 1'b1);
        send_row(2, 1'b1);
        send_row(2, 1'b1);
        send_row(2, 1'b0);
        send_row(2, 1'b1);
        drain();
    endtask

    task automatic test_max_width();
        write_size(REG_WORDS_PER_ROW, 255);
        write_size(REG_ROWS_PER_FRAME, 2);
        send_row(128, 1'b1);
        send_row(128, 1'b0);
        drain();
    endtask

    task automatic test_max_height();
        write_size(REG_WORDS_PER_ROW, 1);
        write_size(REG_ROWS_PER_FRAME, 2047);
        for (int r = 0; r < 40; r++)
            send_row(1, 1'b1);
        write_size(REG_ROWS_PER_FRAME, 40);
        send_row(1, 1'b1);
        send_row(1, 1'b0);
        send_row(1, 1'b1);
        drain();
    endtask

    task automatic test_random_frames();
        int                width;
        int                height;
        int                diff_pct;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        for (int phase = 0; phase < 7; phase++)
        begin
            width  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
            height = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 8);
            write_size(REG_WORDS_PER_ROW,
                       {16'($urandom_range(0, 16'hffff)), 8'h00, 8'(width)});
            write_size(REG_ROWS_PER_FRAME,
                       {16'($urandom_range(0, 16'hffff)), 5'h00, 11'(height)});
            gaps_on  = (phase % 3 != 0);
            diff_pct = $urandom_range(5, 40);
            for (int n = 0; n < 35; n++)
            begin
                a = {$urandom, $urandom};
                b = a;
                if ($urandom_range(0, 99) < diff_pct)
                begin
                    case ($urandom_range(0, 2))
                        0: b = a ^ (64'd1 << $urandom_range(0, 63));
                        1: b = ~a;
                        default: b = {$urandom, $urandom};
                    endcase
                end
                send_pair(a, b);
            end
        end
        gaps_on = 1'b0;
        drain();
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        old_word <= '0;
        new_word <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_size();
        test_shrink_midframe();
        test_zero_size_extremes();
        test_last_row_clean();
        gaps_on = 1'b1;
        test_max_width();
        gaps_on = 1'b0;
        test_max_height();
        test_random_frames();

        drain();
        $display("frame_dirty_row_detector_top_tb: %0d word pairs, %0d size writes",
                 pairs_sent, size_writes);
        $display("frame_dirty_row_detector_top_tb: %0d regions checked, %0d mismatches",
                 regions_seen, error_count);
        if (error_count == 0)
            $display("frame_dirty_row_detector_top_tb: clean");
        else
            $display("frame_dirty_row_detector_top_tb: errors");
        $finish;
    end

endmodule
